// ===== hw/rtl/obfs_pkg.sv =====
// oriented box fill scan: shared constants, register codes and item types
// used by every module of the block; depends on nothing

package obfs_pkg;

  // frame and fixed-point setup
  localparam int FRAME_WIDTH    = 1024;
  localparam int FRAME_HEIGHT   = 1024;
  localparam int AXIS_FRAC_BITS = 14;

  // field widths
  localparam int CTR_W   = 13;
  localparam int AXIS_W  = 16;
  localparam int HALF_W  = 11;
  localparam int COLOR_W = 24;
  localparam int PIX_W   = 10;

  // derived widths
  localparam int FRAME_MAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int COORD_W   = $clog2(FRAME_MAX) + 1;
  localparam int MAG_W     = AXIS_W;
  localparam int PRD_W     = MAG_W + HALF_W;
  localparam int EXT_W     = PRD_W + 1;
  localparam int CSH_W     = CTR_W + AXIS_FRAC_BITS;
  localparam int SPAN_W    = ((CSH_W > EXT_W) ? CSH_W : EXT_W) + 2;
  localparam int VEC_W     = ((COORD_W > CTR_W) ? COORD_W : CTR_W) + 1;
  localparam int PROD_W    = VEC_W + AXIS_W;
  localparam int DOT_W     = PROD_W + 1;

  // span constants, scaled by the axis fraction
  localparam logic signed [SPAN_W-1:0] SPAN_ROUND = SPAN_W'((1 << AXIS_FRAC_BITS) - 1);
  localparam logic signed [SPAN_W-1:0] X_LIM =
    SPAN_W'(FRAME_WIDTH * (1 << AXIS_FRAC_BITS));
  localparam logic signed [SPAN_W-1:0] X_TOP =
    SPAN_W'((FRAME_WIDTH - 1) * (1 << AXIS_FRAC_BITS));
  localparam logic signed [SPAN_W-1:0] Y_LIM =
    SPAN_W'(FRAME_HEIGHT * (1 << AXIS_FRAC_BITS));
  localparam logic signed [SPAN_W-1:0] Y_TOP =
    SPAN_W'((FRAME_HEIGHT - 1) * (1 << AXIS_FRAC_BITS));

  // queues
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_AXIS_COS    = 3'd2,
    REG_AXIS_SIN    = 3'd3,
    REG_HALF_WIDTH  = 3'd4,
    REG_HALF_HEIGHT = 3'd5,
    REG_DRAW_COLOR  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CTR_W-1:0]  center_x;
    logic signed [CTR_W-1:0]  center_y;
    logic signed [AXIS_W-1:0] axis_cos;
    logic signed [AXIS_W-1:0] axis_sin;
    logic [HALF_W-1:0]        half_width;
    logic [HALF_W-1:0]        half_height;
    logic [COLOR_W-1:0]       draw_color;
  } cfg_t;

  typedef enum logic [1:0] {
    ITEM_IDLE  = 2'd0,
    ITEM_START = 2'd1,
    ITEM_PIXEL = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } scan_item_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic               covered;
    logic [COLOR_W-1:0] pixel_color;
    logic               scan_last;
  } result_t;

endpackage

// ===== hw/rtl/oriented_box_fill_scan_top.sv =====
// Oriented box fill scanner.
// Input channel: push / full. An item is taken when push is high and full is
// low. start_scan = 1 latches the box registers and restarts the scan, 0 asks
// for the next pixel of the bounding box, row by row.
// Result channel: empty / pop. The oldest result sits on the pixel ports while
// empty is low and leaves when pop is high. Every item gives exactly one
// result; a start item and an advance with no scan running give an all-zero
// result with pixel_valid low.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one box register a
// cycle; unknown indexes are dropped. Write only while the block is idle.
// The path from a taken item to the result ports runs through the item queue,
// the offset stage, the product stage, the dot-product stage and the result queue.
// Throughput: one advance item per cycle while full is low. A start item holds
// full high while the bounding box is worked out (products, sums, clip, then
// span).
// Reset (rst, synchronous): no scan running, queues empty, box registers at
// centre 0, axis (1, 0), zero extents, colour 0.
// A stalled receiver fills the result queue, freezes the pixel pipeline,
// then the item queue, and finally raises full.
// depends on obfs_pkg, obfs_front, obfs_queue, obfs_back

module oriented_box_fill_scan_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           start_scan,
  output logic                           empty,
  input  logic                           pop,
  output logic                           pixel_valid,
  output logic [obfs_pkg::PIX_W-1:0]     pixel_x,
  output logic [obfs_pkg::PIX_W-1:0]     pixel_y,
  output logic                           covered,
  output logic [obfs_pkg::COLOR_W-1:0]   pixel_color,
  output logic                           scan_last,
  input  logic                           cfg_wr_en,
  input  logic [obfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [obfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import obfs_pkg::*;

  cfg_t       cfg;
  logic       q_push, q_full, q_pop, q_empty;
  scan_item_t q_in, q_out;
  result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.axis_cos    <= AXIS_W'(1 << AXIS_FRAC_BITS);
      cfg.axis_sin    <= '0;
      cfg.half_width  <= '0;
      cfg.half_height <= '0;
      cfg.draw_color  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CENTER_X:    cfg.center_x    <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:    cfg.center_y    <= cfg_data[CTR_W-1:0];
        REG_AXIS_COS:    cfg.axis_cos    <= cfg_data[AXIS_W-1:0];
        REG_AXIS_SIN:    cfg.axis_sin    <= cfg_data[AXIS_W-1:0];
        REG_HALF_WIDTH:  cfg.half_width  <= cfg_data[HALF_W-1:0];
        REG_HALF_HEIGHT: cfg.half_height <= cfg_data[HALF_W-1:0];
        REG_DRAW_COLOR:  cfg.draw_color  <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  obfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .start_scan (start_scan),
    .full       (full),
    .q_push     (q_push),
    .q_item     (q_in),
    .q_full     (q_full)
  );

  obfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  obfs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  assign pixel_valid = result.pixel_valid;
  assign pixel_x     = result.pixel_x;
  assign pixel_y     = result.pixel_y;
  assign covered     = result.covered;
  assign pixel_color = result.pixel_color;
  assign scan_last   = result.scan_last;

endmodule

// ===== hw/rtl/obfs_front.sv =====
// oriented box fill scan: front end, takes items, works out the bounding box
// on a start item and walks the scan position; depends on obfs_pkg

module obfs_front (
  input  logic               clk,
  input  logic               rst,
  input  obfs_pkg::cfg_t     cfg,
  input  logic               push,
  input  logic               start_scan,
  output logic               full,
  output logic               q_push,
  output obfs_pkg::scan_item_t q_item,
  input  logic               q_full
);
  import obfs_pkg::*;

  typedef enum logic [1:0] {F_RUN, F_SUM, F_CLIP, F_SET} state_t;

  state_t state;
  logic   active;
  logic [COORD_W-1:0] col, row, min_col, min_row, end_col, end_row;

  logic [PRD_W-1:0] cos_hw, sin_hh, sin_hw, cos_hh;
  logic [EXT_W-1:0] ext_x, ext_y;
  logic signed [SPAN_W-1:0] mn_x, mx_x, mn_y, mx_y;

  logic acc;
  logic [MAG_W-1:0] mag_cos, mag_sin;
  logic [COORD_W-1:0] col_inc, row_inc;
  logic last_col, last_row;
  logic signed [SPAN_W-1:0] cx_sh, cy_sh, lo_x, hi_x, lo_y, hi_y;
  logic signed [SPAN_W-1:0] s_x, e_x, s_y, e_y;
  logic ok_x, ok_y;

  assign full = (state != F_RUN) || q_full;
  assign acc  = push && !full;

  // a most negative axis still gives its true magnitude as unsigned
  assign mag_cos = MAG_W'(cfg.axis_cos[AXIS_W-1] ? -cfg.axis_cos : cfg.axis_cos);
  assign mag_sin = MAG_W'(cfg.axis_sin[AXIS_W-1] ? -cfg.axis_sin : cfg.axis_sin);

  assign col_inc  = col + 1'b1;
  assign row_inc  = row + 1'b1;
  assign last_col = col_inc >= end_col;
  assign last_row = row_inc >= end_row;

  assign cx_sh = SPAN_W'(cfg.center_x) <<< AXIS_FRAC_BITS;
  assign cy_sh = SPAN_W'(cfg.center_y) <<< AXIS_FRAC_BITS;
  assign lo_x  = cx_sh - SPAN_W'(ext_x);
  assign hi_x  = cx_sh + SPAN_W'(ext_x);
  assign lo_y  = cy_sh - SPAN_W'(ext_y);
  assign hi_y  = cy_sh + SPAN_W'(ext_y);

  assign s_x  = mn_x >>> AXIS_FRAC_BITS;
  assign e_x  = (mx_x + SPAN_ROUND) >>> AXIS_FRAC_BITS;
  assign s_y  = mn_y >>> AXIS_FRAC_BITS;
  assign e_y  = (mx_y + SPAN_ROUND) >>> AXIS_FRAC_BITS;
  assign ok_x = (mx_x > 0) && (s_x < e_x);
  assign ok_y = (mx_y > 0) && (s_y < e_y);

  always_comb begin
    q_push      = acc;
    q_item.col  = col;
    q_item.row  = row;
    q_item.last = last_col && last_row;
    if (start_scan) begin
      q_item.kind = ITEM_START;
    end else if (active) begin
      q_item.kind = ITEM_PIXEL;
    end else begin
      q_item.kind = ITEM_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_RUN;
      active  <= 1'b0;
      col     <= '0;
      row     <= '0;
      min_col <= '0;
      min_row <= '0;
      end_col <= '0;
      end_row <= '0;
    end else begin
      unique case (state)
        F_RUN: begin
          if (acc) begin
            if (start_scan) begin
              state <= F_SUM;
            end else if (active) begin
              if (last_col && last_row) begin
                active <= 1'b0;
              end else if (last_col) begin
                col <= min_col;
                row <= row_inc;
              end else begin
                col <= col_inc;
              end
            end
          end
        end
        F_SUM:  state <= F_CLIP;
        F_CLIP: state <= F_SET;
        F_SET: begin
          state   <= F_RUN;
          min_col <= COORD_W'(s_x);
          end_col <= COORD_W'(e_x);
          min_row <= COORD_W'(s_y);
          end_row <= COORD_W'(e_y);
          col     <= COORD_W'(s_x);
          row     <= COORD_W'(s_y);
          active  <= ok_x && ok_y;
        end
        default: state <= F_RUN;
      endcase
    end
  end

  // box arithmetic, one step per cycle; all but the products while held off
  always_ff @(posedge clk) begin
    if (acc && start_scan) begin
      cos_hw <= PRD_W'(mag_cos) * PRD_W'(cfg.half_width);
      sin_hh <= PRD_W'(mag_sin) * PRD_W'(cfg.half_height);
      sin_hw <= PRD_W'(mag_sin) * PRD_W'(cfg.half_width);
      cos_hh <= PRD_W'(mag_cos) * PRD_W'(cfg.half_height);
    end
    if (state == F_SUM) begin
      ext_x <= EXT_W'(cos_hw) + EXT_W'(sin_hh);
      ext_y <= EXT_W'(sin_hw) + EXT_W'(cos_hh);
    end
    if (state == F_CLIP) begin
      mn_x <= (lo_x < 0) ? '0 : lo_x;
      mx_x <= (hi_x >= X_LIM) ? X_TOP : hi_x;
      mn_y <= (lo_y < 0) ? '0 : lo_y;
      mx_y <= (hi_y >= Y_LIM) ? Y_TOP : hi_y;
    end
  end

endmodule

// ===== hw/rtl/obfs_queue.sv =====
// oriented box fill scan: short item queue between front and back end
// depends on obfs_pkg

module obfs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  obfs_pkg::scan_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output obfs_pkg::scan_item_t pop_item,
  output logic                 empty
);
  import obfs_pkg::*;

  scan_item_t          slots [QDEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign full     = count == QCNT_W'(QDEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/obfs_back.sv =====
// oriented box fill scan: back end, dot-product pipeline, coverage test and
// result queue; depends on obfs_pkg

module obfs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  obfs_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  obfs_pkg::scan_item_t q_item,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output obfs_pkg::result_t    result
);
  import obfs_pkg::*;

  // box set latched when a start item enters
  logic signed [CTR_W-1:0]  lat_cx, lat_cy;
  logic signed [AXIS_W-1:0] lat_cos, lat_sin;
  logic [HALF_W-1:0]        lat_hw, lat_hh;
  logic [COLOR_W-1:0]       lat_color;

  // stage 1: offsets from the centre
  logic                     s1_valid, s1_pix, s1_last;
  logic [PIX_W-1:0]         s1_x, s1_y;
  logic signed [VEC_W-1:0]  s1_vx, s1_vy;
  logic signed [AXIS_W-1:0] s1_cos, s1_sin;
  logic [HALF_W-1:0]        s1_hw, s1_hh;
  logic [COLOR_W-1:0]       s1_color;

  // stage 2: products
  logic                     s2_valid, s2_pix, s2_last;
  logic [PIX_W-1:0]         s2_x, s2_y;
  logic signed [PROD_W-1:0] s2_rc, s2_rs, s2_uc, s2_us;
  logic [HALF_W-1:0]        s2_hw, s2_hh;
  logic [COLOR_W-1:0]       s2_color;

  // stage 3: dot products
  logic                     s3_valid, s3_pix, s3_last;
  logic [PIX_W-1:0]         s3_x, s3_y;
  logic signed [DOT_W-1:0]  s3_rd, s3_ud;
  logic [HALF_W-1:0]        s3_hw, s3_hh;
  logic [COLOR_W-1:0]       s3_color;

  // result queue
  result_t                  res_slots [QDEPTH];
  logic [QPTR_W-1:0]        wptr, rptr;
  logic [QCNT_W-1:0]        count;
  logic                     out_full, res_push, res_pop;

  logic                     adv, is_pix, cov;
  logic signed [VEC_W-1:0]  vx_w, vy_w;
  logic signed [DOT_W-1:0]  lim_w, lim_h;
  result_t                  res_w;

  assign out_full = count == QCNT_W'(QDEPTH);
  assign empty    = count == '0;
  assign adv      = !(s3_valid && out_full);
  assign q_pop    = adv && !q_empty;
  assign res_push = adv && s3_valid;
  assign res_pop  = pop && !empty;
  assign result   = res_slots[rptr];

  assign is_pix = q_item.kind == ITEM_PIXEL;
  assign vx_w   = VEC_W'(signed'({1'b0, q_item.col})) - VEC_W'(lat_cx);
  assign vy_w   = VEC_W'(signed'({1'b0, q_item.row})) - VEC_W'(lat_cy);

  assign lim_w = DOT_W'(s3_hw) << AXIS_FRAC_BITS;
  assign lim_h = DOT_W'(s3_hh) << AXIS_FRAC_BITS;
  assign cov   = s3_pix && (s3_rd <= lim_w) && (s3_rd >= -lim_w)
                 && (s3_ud <= lim_h) && (s3_ud >= -lim_h);

  always_comb begin
    res_w.pixel_valid = s3_pix;
    res_w.pixel_x     = s3_pix ? s3_x : '0;
    res_w.pixel_y     = s3_pix ? s3_y : '0;
    res_w.covered     = cov;
    res_w.pixel_color = cov ? s3_color : '0;
    res_w.scan_last   = s3_pix && s3_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      wptr      <= '0;
      rptr      <= '0;
      count     <= '0;
      lat_cx    <= '0;
      lat_cy    <= '0;
      lat_cos   <= '0;
      lat_sin   <= '0;
      lat_hw    <= '0;
      lat_hh    <= '0;
      lat_color <= '0;
    end else begin
      if (adv) begin
        s1_valid <= q_pop;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
      end
      // later items see the new box set, earlier ones carry theirs along
      if (q_pop && q_item.kind == ITEM_START) begin
        lat_cx    <= cfg.center_x;
        lat_cy    <= cfg.center_y;
        lat_cos   <= cfg.axis_cos;
        lat_sin   <= cfg.axis_sin;
        lat_hw    <= cfg.half_width;
        lat_hh    <= cfg.half_height;
        lat_color <= cfg.draw_color;
      end
      if (res_push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (res_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (res_push && !res_pop) begin
        count <= count + 1'b1;
      end else if (res_pop && !res_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix   <= q_pop && is_pix;
      s1_last  <= q_item.last;
      s1_x     <= PIX_W'(q_item.col);
      s1_y     <= PIX_W'(q_item.row);
      s1_vx    <= vx_w;
      s1_vy    <= vy_w;
      s1_cos   <= lat_cos;
      s1_sin   <= lat_sin;
      s1_hw    <= lat_hw;
      s1_hh    <= lat_hh;
      s1_color <= lat_color;

      s2_pix   <= s1_pix;
      s2_last  <= s1_last;
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_rc    <= PROD_W'(s1_vx) * PROD_W'(s1_cos);
      s2_rs    <= PROD_W'(s1_vy) * PROD_W'(s1_sin);
      s2_uc    <= PROD_W'(s1_vy) * PROD_W'(s1_cos);
      s2_us    <= PROD_W'(s1_vx) * PROD_W'(s1_sin);
      s2_hw    <= s1_hw;
      s2_hh    <= s1_hh;
      s2_color <= s1_color;

      s3_pix   <= s2_pix;
      s3_last  <= s2_last;
      s3_x     <= s2_x;
      s3_y     <= s2_y;
      s3_rd    <= DOT_W'(s2_rc) + DOT_W'(s2_rs);
      s3_ud    <= DOT_W'(s2_uc) - DOT_W'(s2_us);
      s3_hw    <= s2_hw;
      s3_hh    <= s2_hh;
      s3_color <= s2_color;
    end
    if (res_push) begin
      res_slots[wptr] <= res_w;
    end
  end

endmodule

// ===== hw/rtl/obfs_checker.sv =====
// oriented box fill scan: port-level checks over time, bound to the top level
// depends on obfs_pkg and oriented_box_fill_scan_top

module obfs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            full,
  input logic                            start_scan,
  input logic                            empty,
  input logic                            pop,
  input logic                            pixel_valid,
  input logic [obfs_pkg::PIX_W-1:0]      pixel_x,
  input logic [obfs_pkg::PIX_W-1:0]      pixel_y,
  input logic                            covered,
  input logic [obfs_pkg::COLOR_W-1:0]    pixel_color,
  input logic                            scan_last,
  input logic                            cfg_wr_en,
  input logic [obfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [obfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a result with no pixel carries nothing else
  a_blank_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pixel_valid) |->
      (pixel_x == '0 && pixel_y == '0 && !covered && !scan_last))
    else $error("result without pixel has non-zero fields");

  // colour only goes out with a covered pixel
  a_color_gated: assert property (@(posedge clk) disable iff (rst)
    (!empty && !covered) |-> (pixel_color == '0))
    else $error("colour on an uncovered pixel");

  // reset leaves the result queue empty and full low
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not empty after reset");

  // a waiting result stays put until popped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_x) && $stable(pixel_y)
                          && $stable(pixel_valid)))
    else $error("waiting result changed");

endmodule

bind oriented_box_fill_scan_top obfs_checker u_obfs_checker (.*);
